@@ design/bffa_pkg.sv @@
package bffa_pkg;

	// Bitmap storage geometry: one memory word holds 64 map entries.
	localparam int WORD_W = 64;
	localparam int BIT_W  = 6;

	// Field widths fixed by the interface.
	localparam int LIM_W  = 11;
	localparam int IDX_W  = 10;
	localparam int WX_W   = LIM_W - BIT_W;

	// The entry count register never exceeds 2047, so at most 32 words are ever searched.
	localparam logic [LIM_W-1:0] BIT_COUNT_RST = 11'd1024;

	// Register index of the entry count register (address bit 2 selects the register).
	localparam logic REG_BIT_COUNT = 1'b0;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_ALLOC = 2'd0,
		ST_FULL  = 2'd1,
		ST_FREED = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	// Access request from the sequencer to the bitmap memory.
	typedef struct packed {
		logic              rd_en;
		logic [WX_W-1:0]   rd_addr;
		logic              wr_en;
		logic [WX_W-1:0]   wr_addr;
		logic [WORD_W-1:0] wr_data;
	} map_req_t;

endpackage

@@ design/bitmap_first_free_allocator.sv @@
// Channel      Direction  Contents
// s_axis       in         tdata: entry_index; tuser: req_type
// m_axis       out        tdata: result_index; tuser: status
// APB          in/out     register 0 at address 0: bit_count
//
// An allocate passes through accept, a search of one 64-entry word at a time by the
// shared word finder (up to ceil(min(bit_count, MAP_BITS) / 64) words, 16 at 1024 entries),
// and a result state; with a zero entry count it goes from accept straight to the result.
// A free in range passes through accept, read-modify-write of its word, and result;
// an out-of-range free goes from accept straight to the result. After reset a clearing
// pass writes every bitmap word, ceil(MAP_BITS / 64) words, while s_axis_tready stays low.
// A stalled m_axis holds the result and the next item waits.
module bitmap_first_free_allocator #(
	parameter int MAP_BITS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [9:0] entry_index
	input  logic [0:0]  s_axis_tuser,   // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [9:0] result_index
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bffa_pkg::*;

	localparam int WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_FREE = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t            state_q;
	logic [LIM_W-1:0]  bit_count_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WX_W-1:0]   ex_q;
	logic [IDX_W-1:0]  res_idx_q;
	status_t           res_st_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	status_t           out_st_q;

	logic [LIM_W-1:0]  lim;
	logic [LIM_W-1:0]  lim_m1;
	logic [WX_W-1:0]   last_wx;
	logic              map_rdy;
	logic [WORD_W-1:0] rdata;
	map_req_t          mreq;
	logic              found;
	logic [BIT_W-1:0]  bit_pos;
	logic              in_fire;
	req_t              in_req;
	logic [IDX_W-1:0]  in_idx;
	logic              idx_ok;
	logic              out_free;
	logic              cfg_wr;

	// Entry count in effect, capped at the map size.
	assign lim     = (int'(bit_count_q) < MAP_BITS) ? bit_count_q : LIM_W'(MAP_BITS);
	assign lim_m1  = lim - 1'b1;
	assign last_wx = lim_m1[LIM_W-1:BIT_W];

	assign s_axis_tready = (state_q == S_IDLE) && map_rdy;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_req        = req_t'(s_axis_tuser[0]);
	assign in_idx        = s_axis_tdata[IDX_W-1:0];
	assign idx_ok        = {1'b0, in_idx} < lim;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Configuration port.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BIT_COUNT) ? 32'(bit_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= BIT_COUNT_RST;
		end else if (cfg_wr && (paddr[2] == REG_BIT_COUNT)) begin
			bit_count_q <= pwdata[LIM_W-1:0];
		end
	end

	bffa_map #(
		.WORDS(WORDS)
	) u_map (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.rdata (rdata),
		.ready (map_rdy)
	);

	bffa_find u_find (
		.word    (rdata),
		.word_idx(ex_q),
		.lim     (lim),
		.found   (found),
		.bit_pos (bit_pos)
	);

	// Memory accesses issued by the sequencer.
	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_IDLE: begin
				mreq.rd_en   = in_fire;
				mreq.rd_addr = (in_req == REQ_ALLOC) ? '0 : WX_W'(in_idx[IDX_W-1:BIT_W]);
			end
			S_SCAN: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = ex_q + 1'b1;
				mreq.wr_en   = found;
				mreq.wr_addr = ex_q;
				mreq.wr_data = rdata | (WORD_W'(1) << bit_pos);
			end
			S_FREE: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = WX_W'(idx_q[IDX_W-1:BIT_W]);
				mreq.wr_data = rdata & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
			end
			S_RESP: begin
				mreq = '0;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ex_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						ex_q <= '0;
						if (in_req == REQ_ALLOC) begin
							state_q <= (lim == '0) ? S_RESP : S_SCAN;
						end else begin
							state_q <= idx_ok ? S_FREE : S_RESP;
						end
					end
				end
				S_SCAN: begin
					if (found || (ex_q == last_wx)) begin
						state_q <= S_RESP;
					end else begin
						ex_q <= ex_q + 1'b1;
					end
				end
				S_FREE: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if ((state_q == S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_q     <= in_idx;
			res_idx_q <= '0;
			res_st_q  <= (in_req == REQ_ALLOC) ? ST_FULL : ST_BAD;
		end
		if (state_q == S_SCAN) begin
			if (found) begin
				res_idx_q <= IDX_W'({ex_q, bit_pos});
				res_st_q  <= ST_ALLOC;
			end
		end
		if (state_q == S_FREE) begin
			res_idx_q <= idx_q;
			res_st_q  <= ST_FREED;
		end
		if ((state_q == S_RESP) && out_free) begin
			out_idx_q <= res_idx_q;
			out_st_q  <= res_st_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = 16'(out_idx_q);
	assign m_axis_tuser  = out_st_q;

endmodule

@@ design/bffa_map.sv @@
module bffa_map #(
	parameter int WORDS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bffa_pkg::map_req_t     req,
	output logic [63:0]            rdata,
	output logic                   ready
);
	import bffa_pkg::*;

	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [WORD_W-1:0] mem_q [WORDS];
	logic [WORD_W-1:0] rdata_q;
	logic [AW-1:0]     clr_q;
	logic              clearing_q;

	// Clearing pass after reset: one word per cycle until every word is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_q == AW'(WORDS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Single write port and a registered read port.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_q[clr_q] <= '0;
		end else if (req.wr_en) begin
			mem_q[AW'(req.wr_addr)] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[AW'(req.rd_addr)];
		end
	end

	assign rdata = rdata_q;
	assign ready = !clearing_q;

endmodule

@@ design/bffa_find.sv @@
module bffa_find (
	input  logic [63:0]                    word,
	input  logic [bffa_pkg::WX_W-1:0]      word_idx,
	input  logic [bffa_pkg::LIM_W-1:0]     lim,
	output logic                           found,
	output logic [bffa_pkg::BIT_W-1:0]     bit_pos
);
	import bffa_pkg::*;

	logic [LIM_W:0]    base;
	logic [LIM_W:0]    rem;
	logic              below;
	logic [WORD_W-1:0] valid;
	logic [WORD_W-1:0] free_bits;

	// Entries of this word that lie below the entry count.
	always_comb begin
		base  = {1'b0, word_idx, {BIT_W{1'b0}}};
		below = {1'b0, lim} > base;
		rem   = {1'b0, lim} - base;
		for (int b = 0; b < WORD_W; b++) begin
			valid[b] = below && ((LIM_W + 1)'(b) < rem);
		end
	end

	assign free_bits = ~word & valid;
	assign found     = |free_bits;

	// Lowest free entry wins.
	always_comb begin
		bit_pos = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				bit_pos = BIT_W'(b);
			end
		end
	end

endmodule
